[hdl/msd_pkg.sv]
// Shared types and constants for the MessagePack stream decoder.
// Used by the classifier, the item queue, the executor and the top level.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

    // Token kinds.
    localparam logic [3:0] K_NIL  = 4'd0;
    localparam logic [3:0] K_BOOL = 4'd1;
    localparam logic [3:0] K_UINT = 4'd2;
    localparam logic [3:0] K_SINT = 4'd3;
    localparam logic [3:0] K_F32  = 4'd4;
    localparam logic [3:0] K_STR  = 4'd5;
    localparam logic [3:0] K_BIN  = 4'd6;
    localparam logic [3:0] K_ARR  = 4'd7;
    localparam logic [3:0] K_MAP  = 4'd8;
    localparam logic [3:0] K_BYTE = 4'd9;
    localparam logic [3:0] K_ERR  = 4'd10;

    // Error codes.
    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_UNKNOWN = 3'd1;
    localparam logic [2:0] E_WIDE    = 3'd2;
    localparam logic [2:0] E_LEN     = 3'd3;
    localparam logic [2:0] E_F64     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_INT_BYTES   = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD_LEN = 2'd1;

    // Lead bytes with a fixed meaning.
    localparam logic [7:0] LEAD_NIL   = 8'hc0;
    localparam logic [7:0] LEAD_FALSE = 8'hc2;
    localparam logic [7:0] LEAD_TRUE  = 8'hc3;
    localparam logic [7:0] LEAD_BIN8  = 8'hc4;
    localparam logic [7:0] LEAD_BIN16 = 8'hc5;
    localparam logic [7:0] LEAD_BIN32 = 8'hc6;
    localparam logic [7:0] LEAD_F32   = 8'hca;
    localparam logic [7:0] LEAD_F64   = 8'hcb;
    localparam logic [7:0] LEAD_U8    = 8'hcc;
    localparam logic [7:0] LEAD_U16   = 8'hcd;
    localparam logic [7:0] LEAD_U32   = 8'hce;
    localparam logic [7:0] LEAD_U64   = 8'hcf;
    localparam logic [7:0] LEAD_S8    = 8'hd0;
    localparam logic [7:0] LEAD_S16   = 8'hd1;
    localparam logic [7:0] LEAD_S32   = 8'hd2;
    localparam logic [7:0] LEAD_S64   = 8'hd3;
    localparam logic [7:0] LEAD_STR8  = 8'hd9;
    localparam logic [7:0] LEAD_STR16 = 8'hda;
    localparam logic [7:0] LEAD_STR32 = 8'hdb;
    localparam logic [7:0] LEAD_ARR16 = 8'hdc;
    localparam logic [7:0] LEAD_ARR32 = 8'hdd;
    localparam logic [7:0] LEAD_MAP16 = 8'hde;
    localparam logic [7:0] LEAD_MAP32 = 8'hdf;

    localparam logic [7:0] FIXSTR_MASK = 8'h1f;
    localparam logic [7:0] FIXCNT_MASK = 8'h0f;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_GATHER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    // What a byte means if it turns out to be a lead byte.
    typedef enum logic [2:0] {
        OP_EMIT   = 3'd0,  // complete token right away
        OP_HDR    = 3'd1,  // fixstr header, length check applies
        OP_GATHER = 3'd2,  // gather a big-endian length or float
        OP_INT    = 3'd3,  // gather an integer, width check applies
        OP_ERR    = 3'd4   // refused lead byte
    } lead_op_t;

    typedef struct packed {
        logic [7:0] raw;     // the byte itself
        lead_op_t   op;
        logic [3:0] kind;
        logic [3:0] nbytes;
        logic [2:0] err;
        logic [7:0] imm;     // immediate value or length
        logic       sext;    // sign-extend imm to 64 bits
    } item_t;

endpackage

`default_nettype wire

[hdl/msd_front.sv]
// Front end: classifies each incoming byte as a possible lead byte.
// Depends on msd_pkg for the item record and the lead byte constants.
`timescale 1ns / 1ps
`default_nettype none

module msd_front (
    input  wire logic [7:0]   in_byte,
    output msd_pkg::item_t    item
);
    import msd_pkg::*;

    always_comb
    begin
        item.raw    = in_byte;
        item.op     = OP_ERR;
        item.kind   = K_ERR;
        item.nbytes = 4'd0;
        item.err    = E_UNKNOWN;
        item.imm    = in_byte;
        item.sext   = 1'b0;
        case (in_byte) inside
            [8'h00:8'h7f]:
            begin
                item.op  = OP_EMIT;
                item.kind = K_UINT;
                item.err = E_NONE;
            end
            [8'he0:8'hff]:
            begin
                item.op   = OP_EMIT;
                item.kind = K_SINT;
                item.err  = E_NONE;
                item.sext = 1'b1;
            end
            [8'h80:8'h8f]:
            begin
                item.op   = OP_EMIT;
                item.kind = K_MAP;
                item.err  = E_NONE;
                item.imm  = in_byte & FIXCNT_MASK;
            end
            [8'h90:8'h9f]:
            begin
                item.op   = OP_EMIT;
                item.kind = K_ARR;
                item.err  = E_NONE;
                item.imm  = in_byte & FIXCNT_MASK;
            end
            [8'ha0:8'hbf]:
            begin
                item.op   = OP_HDR;
                item.kind = K_STR;
                item.err  = E_NONE;
                item.imm  = in_byte & FIXSTR_MASK;
            end
            LEAD_NIL, LEAD_FALSE, LEAD_TRUE:
            begin
                item.op   = OP_EMIT;
                item.kind = (in_byte == LEAD_NIL) ? K_NIL : K_BOOL;
                item.err  = E_NONE;
                item.imm  = (in_byte == LEAD_TRUE) ? 8'd1 : 8'd0;
            end
            LEAD_BIN8, LEAD_BIN16, LEAD_BIN32:
            begin
                item.op     = OP_GATHER;
                item.kind   = K_BIN;
                item.err    = E_NONE;
                item.nbytes = (in_byte == LEAD_BIN8)  ? 4'd1 :
                              (in_byte == LEAD_BIN16) ? 4'd2 : 4'd4;
            end
            LEAD_F32:
            begin
                item.op     = OP_GATHER;
                item.kind   = K_F32;
                item.err    = E_NONE;
                item.nbytes = 4'd4;
            end
            LEAD_F64:
            begin
                item.err = E_F64;
            end
            LEAD_U8, LEAD_U16, LEAD_U32, LEAD_U64,
            LEAD_S8, LEAD_S16, LEAD_S32, LEAD_S64:
            begin
                item.op     = OP_INT;
                item.kind   = in_byte[4] ? K_SINT : K_UINT;
                item.err    = E_NONE;
                item.nbytes = 4'd1 << in_byte[1:0];
            end
            LEAD_STR8, LEAD_STR16, LEAD_STR32:
            begin
                item.op     = OP_GATHER;
                item.kind   = K_STR;
                item.err    = E_NONE;
                item.nbytes = (in_byte == LEAD_STR8)  ? 4'd1 :
                              (in_byte == LEAD_STR16) ? 4'd2 : 4'd4;
            end
            LEAD_ARR16, LEAD_ARR32, LEAD_MAP16, LEAD_MAP32:
            begin
                item.op     = OP_GATHER;
                item.kind   = in_byte[1] ? K_MAP : K_ARR;
                item.err    = E_NONE;
                item.nbytes = in_byte[0] ? 4'd4 : 4'd2;
            end
            default:
            begin
                item.err = E_UNKNOWN;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/msd_queue.sv]
// Two-entry queue of classified items between the front end and the executor.
// Depends on msd_pkg for the item record.
`timescale 1ns / 1ps
`default_nettype none

module msd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire msd_pkg::item_t  push_item,
    input  wire logic            pop,
    output logic                 full,
    output logic                 head_valid,
    output msd_pkg::item_t       head_item
);
    import msd_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

[hdl/msd_back.sv]
// Executor: carries the decode state, gathers multi-byte values, checks limits
// and holds the output token register. Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_data,
    input  wire logic            head_valid,
    input  wire msd_pkg::item_t  head_item,
    output logic                 pop,
    output logic                 token_valid,
    input  wire logic            token_ready,
    output logic [3:0]           token_kind,
    output logic [63:0]          token_value,
    output logic [2:0]           error_code,
    output logic                 payload_end
);
    import msd_pkg::*;

    logic [3:0]  max_int_bytes_reg;
    logic [31:0] max_payload_len_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pending_kind_reg, pending_kind_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic        neg_reg, neg_next;

    logic        token_valid_reg, token_valid_next;
    logic [3:0]  kind_reg, kind_next;
    logic [63:0] value_reg, value_next;
    logic [2:0]  err_reg, err_next;
    logic        end_reg, end_next;

    logic        do_emit;
    logic        do_hdr;
    logic [3:0]  hdr_kind;
    logic [31:0] hdr_len;
    logic [63:0] acc_base;
    logic [63:0] acc_shift;
    logic        hdr_is_payload;

    assign pop         = head_valid && (!token_valid_reg || token_ready);
    assign token_valid = token_valid_reg;
    assign token_kind  = kind_reg;
    assign token_value = value_reg;
    assign error_code  = err_reg;
    assign payload_end = end_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        pending_kind_next = pending_kind_reg;
        bytes_left_next   = bytes_left_reg;
        acc_next          = acc_reg;
        payload_left_next = payload_left_reg;
        neg_next          = neg_reg;
        do_emit    = 1'b0;
        kind_next  = kind_reg;
        value_next = value_reg;
        err_next   = E_NONE;
        end_next   = 1'b0;
        do_hdr     = 1'b0;
        hdr_kind   = head_item.kind;
        hdr_len    = {24'd0, head_item.imm};

        // The first byte of a signed value decides the fill of the upper bits.
        acc_base  = neg_reg ? {64{head_item.raw[7]}} : acc_reg;
        acc_shift = {acc_base[55:0], head_item.raw};

        if (pop)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    do_emit    = 1'b1;
                    kind_next  = K_BYTE;
                    value_next = {56'd0, head_item.raw};
                    end_next   = (payload_left_reg <= 32'd1);
                    if (payload_left_reg <= 32'd1)
                    begin
                        payload_left_next = 32'd0;
                        phase_next        = PH_IDLE;
                    end
                    else
                    begin
                        payload_left_next = payload_left_reg - 32'd1;
                    end
                end
                PH_GATHER:
                begin
                    acc_next = acc_shift;
                    neg_next = 1'b0;
                    if (bytes_left_reg > 4'd1)
                    begin
                        bytes_left_next = bytes_left_reg - 4'd1;
                    end
                    else
                    begin
                        bytes_left_next = 4'd0;
                        phase_next      = PH_IDLE;
                        if (pending_kind_reg == K_STR || pending_kind_reg == K_BIN ||
                            pending_kind_reg == K_ARR || pending_kind_reg == K_MAP)
                        begin
                            do_hdr   = 1'b1;
                            hdr_kind = pending_kind_reg;
                            hdr_len  = acc_shift[31:0];
                        end
                        else
                        begin
                            do_emit    = 1'b1;
                            kind_next  = pending_kind_reg;
                            value_next = acc_shift;
                        end
                    end
                end
                PH_IDLE:
                begin
                    case (head_item.op)
                        OP_EMIT:
                        begin
                            do_emit    = 1'b1;
                            kind_next  = head_item.kind;
                            value_next = {{56{head_item.sext}}, head_item.imm};
                        end
                        OP_HDR:
                        begin
                            do_hdr = 1'b1;
                        end
                        OP_GATHER:
                        begin
                            phase_next        = PH_GATHER;
                            pending_kind_next = head_item.kind;
                            bytes_left_next   = head_item.nbytes;
                            acc_next          = 64'd0;
                            neg_next          = 1'b0;
                        end
                        OP_INT:
                        begin
                            if (head_item.nbytes > max_int_bytes_reg)
                            begin
                                do_emit    = 1'b1;
                                kind_next  = K_ERR;
                                value_next = {56'd0, head_item.raw};
                                err_next   = E_WIDE;
                            end
                            else
                            begin
                                phase_next        = PH_GATHER;
                                pending_kind_next = head_item.kind;
                                bytes_left_next   = head_item.nbytes;
                                acc_next          = 64'd0;
                                neg_next          = (head_item.kind == K_SINT);
                            end
                        end
                        default:
                        begin
                            do_emit    = 1'b1;
                            kind_next  = K_ERR;
                            value_next = {56'd0, head_item.raw};
                            err_next   = head_item.err;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Header completion: strings and bins are checked against the limit
        // and, when not empty, open a payload run.
        hdr_is_payload = (hdr_kind == K_STR) || (hdr_kind == K_BIN);
        if (do_hdr)
        begin
            do_emit = 1'b1;
            if (hdr_is_payload && (hdr_len > max_payload_len_reg))
            begin
                kind_next  = K_ERR;
                value_next = {32'd0, hdr_len};
                err_next   = E_LEN;
            end
            else
            begin
                kind_next  = hdr_kind;
                value_next = {32'd0, hdr_len};
                if (hdr_is_payload && (hdr_len != 32'd0))
                begin
                    phase_next        = PH_PAYLOAD;
                    payload_left_next = hdr_len;
                end
            end
        end

        if (do_emit)
        begin
            token_valid_next = 1'b1;
        end
        else if (token_ready)
        begin
            token_valid_next = 1'b0;
        end
        else
        begin
            token_valid_next = token_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_int_bytes_reg   <= 4'd8;
            max_payload_len_reg <= 32'hffff_ffff;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MAX_INT_BYTES)
            begin
                max_int_bytes_reg <= cfg_data[3:0];
            end
            else if (cfg_index == CFG_MAX_PAYLOAD_LEN)
            begin
                max_payload_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            pending_kind_reg <= K_NIL;
            bytes_left_reg   <= 4'd0;
            acc_reg          <= 64'd0;
            payload_left_reg <= 32'd0;
            neg_reg          <= 1'b0;
            token_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            pending_kind_reg <= pending_kind_next;
            bytes_left_reg   <= bytes_left_next;
            acc_reg          <= acc_next;
            payload_left_reg <= payload_left_next;
            neg_reg          <= neg_next;
            token_valid_reg  <= token_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            err_reg   <= err_next;
            end_reg   <= end_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid_reg && kind_reg == K_ERR) |-> (err_reg != E_NONE))
        else $error("error token without an error code");
    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid_reg && kind_reg != K_ERR) |-> (err_reg == E_NONE))
        else $error("error code on a regular token");
    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid_reg && end_reg) |-> (kind_reg == K_BYTE))
        else $error("payload end on a token that is not a payload byte");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_GATHER) |-> (bytes_left_reg != 4'd0))
        else $error("gathering with no bytes left");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_left_reg != 32'd0))
        else $error("payload run with zero length");

endmodule

`default_nettype wire

[hdl/msgpack_stream_decoder.sv]
// Top level of the MessagePack stream decoder: classifier, item queue, executor.
// Depends on msd_pkg, msd_front, msd_queue and msd_back.
//
//   Port group   Handshake                  Payload
//   ----------   ------------------------   -------------------------------------------
//   input        in_valid / in_ready        in_byte
//   output       token_valid / token_ready  token_kind, token_value, error_code,
//                                           payload_end
//   config       cfg_we (no wait)           cfg_index, cfg_data
//
// One byte is accepted per cycle in steady state. A byte is written into the
// two-entry queue, and its token, if any, is loaded into the output register when
// the executor pops the byte from the queue; token_valid rises with that load.
// Reset (rst_n low, asynchronous) empties the queue, returns the decoder to the
// idle phase and loads the limits with 8 bytes and 0xffffffff.
// A stalled output holds the executor; the queue then fills and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module msgpack_stream_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    output logic              token_valid,
    input  wire logic         token_ready,
    output logic [3:0]        token_kind,
    output logic [63:0]       token_value,
    output logic [2:0]        error_code,
    output logic              payload_end,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import msd_pkg::*;

    item_t in_item;
    item_t head_item;
    logic  queue_full;
    logic  head_valid;
    logic  pop;
    logic  push;

    // The queue decouples the classifier from the executor; a byte is taken
    // whenever there is room, independent of the output side.
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // Every byte is classified as if it were a lead byte; the executor decides
    // from its phase whether that classification applies.
    msd_front u_front (
        .in_byte (in_byte),
        .item    (in_item)
    );

    msd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (in_item),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // The executor pops one item per cycle while its output register is free
    // or being drained.
    msd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_kind  (token_kind),
        .token_value (token_value),
        .error_code  (error_code),
        .payload_end (payload_end)
    );

endmodule

`default_nettype wire
